[src/lfps_pkg.sv]
// Shared types and constants for the line-follow PID steering block
`default_nettype none

package lfps_pkg;

   // history depth of the per-channel moving average
   localparam int AVG_DEPTH = 3;
   localparam int SLOT_BITS = $clog2(AVG_DEPTH);

   // fixed field widths
   localparam int THR_BITS   = 10;
   localparam int GAIN_BITS  = 10;
   localparam int SPEED_BITS = 11;
   localparam int MASK_BITS  = 3;
   localparam int ERR_BITS   = 5;
   localparam int SUM_BITS   = 7;
   localparam int CORR_BITS  = 11;
   localparam int DRIVE_BITS = 12;

   // steering and PID limits
   localparam int SIDE_STEP  = 4;
   localparam int SIDE_HALF  = 2;
   localparam int ERR_LIMIT  = 10;
   localparam int SUM_LIMIT  = 50;
   localparam int CORR_LIMIT = 1023;

   // remembered side codes (two's complement of -1, 0, +1)
   localparam logic [1:0] SIDE_NONE  = 2'b00;
   localparam logic [1:0] SIDE_RIGHT = 2'b01;
   localparam logic [1:0] SIDE_LEFT  = 2'b11;

   // register file
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;
   localparam int REG_IDX_BITS  = 3;

   localparam logic [REG_IDX_BITS-1:0] REG_THR_LEFT   = 3'd0;
   localparam logic [REG_IDX_BITS-1:0] REG_THR_MIDDLE = 3'd1;
   localparam logic [REG_IDX_BITS-1:0] REG_THR_RIGHT  = 3'd2;
   localparam logic [REG_IDX_BITS-1:0] REG_GAIN_PROP  = 3'd3;
   localparam logic [REG_IDX_BITS-1:0] REG_GAIN_DERIV = 3'd4;
   localparam logic [REG_IDX_BITS-1:0] REG_GAIN_INTEG = 3'd5;
   localparam logic [REG_IDX_BITS-1:0] REG_BASE_SPEED = 3'd6;

   localparam logic [THR_BITS-1:0]          RST_THR_LEFT   = 10'd445;
   localparam logic [THR_BITS-1:0]          RST_THR_MIDDLE = 10'd560;
   localparam logic [THR_BITS-1:0]          RST_THR_RIGHT  = 10'd554;
   localparam logic [GAIN_BITS-1:0]         RST_GAIN_PROP  = 10'd18;
   localparam logic [GAIN_BITS-1:0]         RST_GAIN_DERIV = 10'd150;
   localparam logic [GAIN_BITS-1:0]         RST_GAIN_INTEG = 10'd0;
   localparam logic signed [SPEED_BITS-1:0] RST_BASE_SPEED = -11'sd440;

   // thresholds for the three sensor channels
   typedef struct packed {
      logic [THR_BITS-1:0] left;
      logic [THR_BITS-1:0] middle;
      logic [THR_BITS-1:0] right;
   } thr_cfg_type;

   // gains and base speed for the PID stage
   typedef struct packed {
      logic [GAIN_BITS-1:0]         gain_prop;
      logic [GAIN_BITS-1:0]         gain_deriv;
      logic [GAIN_BITS-1:0]         gain_integ;
      logic signed [SPEED_BITS-1:0] base_speed;
   } pid_cfg_type;

   // PID stage results for one tick
   typedef struct packed {
      logic signed [ERR_BITS-1:0]   line_error;
      logic signed [CORR_BITS-1:0]  correction;
      logic signed [DRIVE_BITS-1:0] left_drive;
      logic signed [DRIVE_BITS-1:0] right_drive;
   } pid_out_type;

endpackage

`default_nettype wire

[src/lfps_csr.sv]
// APB-style register file for thresholds, gains and base speed
`default_nettype none

module lfps_csr
   import lfps_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_psel,
   input  wire logic                     csr_penable,
   input  wire logic                     csr_pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic      [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                          csr_pready,
   output thr_cfg_type                   thr_cfg,
   output pid_cfg_type                   pid_cfg
);

   logic                    wr_en;
   logic [REG_IDX_BITS-1:0] reg_idx;
   thr_cfg_type             thr_ff, thr_in;
   pid_cfg_type             pid_ff, pid_in;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_idx    = csr_paddr[REG_IDX_BITS+1:2];

   // write decode
   always_comb begin
      thr_in = thr_ff;
      pid_in = pid_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_THR_LEFT:   thr_in.left       = csr_pwdata[THR_BITS-1:0];
            REG_THR_MIDDLE: thr_in.middle     = csr_pwdata[THR_BITS-1:0];
            REG_THR_RIGHT:  thr_in.right      = csr_pwdata[THR_BITS-1:0];
            REG_GAIN_PROP:  pid_in.gain_prop  = csr_pwdata[GAIN_BITS-1:0];
            REG_GAIN_DERIV: pid_in.gain_deriv = csr_pwdata[GAIN_BITS-1:0];
            REG_GAIN_INTEG: pid_in.gain_integ = csr_pwdata[GAIN_BITS-1:0];
            REG_BASE_SPEED: pid_in.base_speed = $signed(csr_pwdata[SPEED_BITS-1:0]);
            default: ;
         endcase
      end
   end

   // register storage
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff.left       <= RST_THR_LEFT;
         thr_ff.middle     <= RST_THR_MIDDLE;
         thr_ff.right      <= RST_THR_RIGHT;
         pid_ff.gain_prop  <= RST_GAIN_PROP;
         pid_ff.gain_deriv <= RST_GAIN_DERIV;
         pid_ff.gain_integ <= RST_GAIN_INTEG;
         pid_ff.base_speed <= RST_BASE_SPEED;
      end else begin
         thr_ff <= thr_in;
         pid_ff <= pid_in;
      end
   end

   // read mux
   always_comb begin
      case (reg_idx)
         REG_THR_LEFT:   csr_prdata = CSR_DATA_BITS'(thr_ff.left);
         REG_THR_MIDDLE: csr_prdata = CSR_DATA_BITS'(thr_ff.middle);
         REG_THR_RIGHT:  csr_prdata = CSR_DATA_BITS'(thr_ff.right);
         REG_GAIN_PROP:  csr_prdata = CSR_DATA_BITS'(pid_ff.gain_prop);
         REG_GAIN_DERIV: csr_prdata = CSR_DATA_BITS'(pid_ff.gain_deriv);
         REG_GAIN_INTEG: csr_prdata = CSR_DATA_BITS'(pid_ff.gain_integ);
         REG_BASE_SPEED: csr_prdata = CSR_DATA_BITS'($signed(pid_ff.base_speed));
         default:        csr_prdata = '0;
      endcase
   end

   assign thr_cfg = thr_ff;
   assign pid_cfg = pid_ff;

endmodule

`default_nettype wire

[src/lfps_chan.sv]
// One sensor channel: sample history, floor average and tape detect
`default_nettype none

module lfps_chan
   import lfps_pkg::*;
#(
   parameter int SAMPLE_BITS = 10
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   wr_en,
   input  wire logic [SLOT_BITS-1:0]   slot,
   input  wire logic [SAMPLE_BITS-1:0] sample,
   input  wire logic [THR_BITS-1:0]    threshold,
   output logic                        detect
);

   // floor(sum / depth) > thr  <=>  sum >= depth * (thr + 1)
   localparam int CMP_BITS =
      ((SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS) + $clog2(AVG_DEPTH) + 1;

   logic [SAMPLE_BITS-1:0] hist_ff [AVG_DEPTH];
   logic [SAMPLE_BITS-1:0] hist_in [AVG_DEPTH];
   logic [SAMPLE_BITS-1:0] view    [AVG_DEPTH];
   logic [CMP_BITS-1:0]    sum;
   logic [CMP_BITS-1:0]    limit;

   // history with the current sample dropped into its slot
   always_comb begin
      sum = '0;
      for (int i = 0; i < AVG_DEPTH; i++) begin
         view[i]    = (SLOT_BITS'(i) == slot) ? sample : hist_ff[i];
         hist_in[i] = wr_en ? view[i] : hist_ff[i];
         sum        = sum + CMP_BITS'(view[i]);
      end
   end

   // threshold compare without a divider
   assign limit  = (CMP_BITS'(threshold) + CMP_BITS'(1)) * CMP_BITS'(AVG_DEPTH);
   assign detect = (sum >= limit);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < AVG_DEPTH; i++) begin
            hist_ff[i] <= '0;
         end
      end else begin
         hist_ff <= hist_in;
      end
   end

endmodule

`default_nettype wire

[src/lfps_pid.sv]
// Line error from the detect pattern, PID correction and drive values
`default_nettype none

module lfps_pid
   import lfps_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step,
   input  wire logic [MASK_BITS-1:0] detect,
   input  wire pid_cfg_type          cfg,
   output pid_out_type               result
);

   localparam int PROD_BITS = 19;
   localparam int LIM_BITS  = SPEED_BITS + 1;

   localparam logic signed [ERR_BITS-1:0]  ERR_SIDE = ERR_BITS'(SIDE_STEP);
   localparam logic signed [ERR_BITS-1:0]  ERR_HALF = ERR_BITS'(SIDE_HALF);
   localparam logic signed [ERR_BITS-1:0]  ERR_LOST = ERR_BITS'(ERR_LIMIT);
   localparam logic signed [SUM_BITS:0]    SUM_HI   = (SUM_BITS+1)'(SUM_LIMIT);
   localparam logic signed [SUM_BITS:0]    SUM_LO   = -(SUM_BITS+1)'(SUM_LIMIT);
   localparam logic signed [LIM_BITS-1:0]  LIM_HI   = LIM_BITS'(CORR_LIMIT);
   localparam logic signed [LIM_BITS-1:0]  LIM_LO   = -LIM_BITS'(CORR_LIMIT);

   logic                        dl, dm, dr;
   logic [1:0]                  last_side_ff, last_side_in;
   logic signed [ERR_BITS-1:0]  last_err_ff, last_err_in;
   logic signed [SUM_BITS-1:0]  err_sum_ff, err_sum_in;
   logic signed [ERR_BITS-1:0]  err;
   logic signed [ERR_BITS:0]    deriv;
   logic signed [SUM_BITS:0]    sum_raw;
   logic signed [PROD_BITS-1:0] p_prop, p_deriv, p_integ, corr_raw, corr_sel;
   logic signed [LIM_BITS-1:0]  base_x, neg_base, hi, lo;
   logic signed [CORR_BITS-1:0] corr;

   assign dl = detect[0];
   assign dm = detect[1];
   assign dr = detect[2];

   // line error and remembered side
   always_comb begin
      last_side_in = last_side_ff;
      if ((dl & dm & dr) | (~dl & dm & ~dr)) begin
         err          = '0;
         last_side_in = SIDE_NONE;
      end else if (dl | dm | dr) begin
         if (dl & ~dr) begin
            err = -ERR_SIDE;
         end else if (dr & ~dl) begin
            err = ERR_SIDE;
         end else begin
            err = '0;
         end
         if (last_side_ff == SIDE_NONE && dl) begin
            last_side_in = SIDE_LEFT;
         end else if (last_side_ff == SIDE_NONE && dr) begin
            last_side_in = SIDE_RIGHT;
         end
         // middle plus one side: half step toward that side
         if (dm) begin
            last_side_in = SIDE_NONE;
            err          = dl ? -ERR_HALF : ERR_HALF;
         end
      end else begin
         case (last_side_ff)
            SIDE_LEFT:  err = -ERR_LOST;
            SIDE_RIGHT: err = ERR_LOST;
            default:    err = '0;
         endcase
      end
   end

   // derivative and clamped integral
   assign deriv   = (ERR_BITS+1)'(err) - (ERR_BITS+1)'(last_err_ff);
   assign sum_raw = (SUM_BITS+1)'(err) + (SUM_BITS+1)'(err_sum_ff);

   always_comb begin
      if (sum_raw > SUM_HI) begin
         err_sum_in = SUM_BITS'(SUM_HI);
      end else if (sum_raw < SUM_LO) begin
         err_sum_in = SUM_BITS'(SUM_LO);
      end else begin
         err_sum_in = sum_raw[SUM_BITS-1:0];
      end
   end

   assign last_err_in = err;

   // three gain products and their sum
   assign p_prop   = PROD_BITS'(err) * PROD_BITS'({1'b0, cfg.gain_prop});
   assign p_deriv  = PROD_BITS'(deriv) * PROD_BITS'({1'b0, cfg.gain_deriv});
   assign p_integ  = PROD_BITS'(err_sum_in) * PROD_BITS'({1'b0, cfg.gain_integ});
   assign corr_raw = p_prop + p_deriv + p_integ;

   // correction limits from the base speed, each saturated
   assign base_x   = LIM_BITS'($signed(cfg.base_speed));
   assign neg_base = -base_x;

   always_comb begin
      if (neg_base > LIM_HI) begin
         hi = LIM_HI;
      end else if (neg_base < LIM_LO) begin
         hi = LIM_LO;
      end else begin
         hi = neg_base;
      end
      if (base_x > LIM_HI) begin
         lo = LIM_HI;
      end else if (base_x < LIM_LO) begin
         lo = LIM_LO;
      end else begin
         lo = base_x;
      end
   end

   // upper limit wins over lower limit
   always_comb begin
      if (corr_raw > PROD_BITS'(hi)) begin
         corr_sel = PROD_BITS'(hi);
      end else if (corr_raw < PROD_BITS'(lo)) begin
         corr_sel = PROD_BITS'(lo);
      end else begin
         corr_sel = corr_raw;
      end
   end

   assign corr = corr_sel[CORR_BITS-1:0];

   assign result.line_error  = err;
   assign result.correction  = corr;
   assign result.left_drive  = DRIVE_BITS'(cfg.base_speed) - DRIVE_BITS'(corr);
   assign result.right_drive = DRIVE_BITS'(cfg.base_speed) + DRIVE_BITS'(corr);

   // controller state advances once per tick
   always_ff @(posedge clock) begin
      if (reset) begin
         last_side_ff <= SIDE_NONE;
         last_err_ff  <= '0;
         err_sum_ff   <= '0;
      end else if (step) begin
         last_side_ff <= last_side_in;
         last_err_ff  <= last_err_in;
         err_sum_ff   <= err_sum_in;
      end
   end

endmodule

`default_nettype wire

[src/line_follow_pid_steering.sv]
// Top level of the three-sensor line-follow PID steering block
//
//   channel  ports   direction  content
//   req      req_*   in         three sensor samples and drive flag per beat
//   rsp      rsp_*   out        detect mask, line error, correction, drives
//   csr      csr_*   in/out     thresholds, gains, base speed
//
// One beat per cycle sustained while rsp_ready is high; a taken request beat
// passes through the input register, then the result register, whose
// outputs carry the result.
// Reset clears the sample histories, history slot, PID state and loads
// the register defaults.
// When rsp_ready is low the result register holds, the input register
// still fills, and req_ready drops once both are occupied.
`default_nettype none

module line_follow_pid_steering
   import lfps_pkg::*;
#(
   parameter int SAMPLE_BITS = 10
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   // request channel
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [SAMPLE_BITS-1:0]   req_left_sample,
   input  wire logic [SAMPLE_BITS-1:0]   req_middle_sample,
   input  wire logic [SAMPLE_BITS-1:0]   req_right_sample,
   input  wire logic                     req_drive_request,
   // result channel
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic [MASK_BITS-1:0]          rsp_detect_mask,
   output logic signed [ERR_BITS-1:0]    rsp_line_error,
   output logic signed [CORR_BITS-1:0]   rsp_correction,
   output logic signed [DRIVE_BITS-1:0]  rsp_left_drive,
   output logic signed [DRIVE_BITS-1:0]  rsp_right_drive,
   output logic                          rsp_drive_valid,
   // configuration port
   input  wire logic                     csr_psel,
   input  wire logic                     csr_penable,
   input  wire logic                     csr_pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic      [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                          csr_pready
);

   thr_cfg_type            thr_cfg;
   pid_cfg_type            pid_cfg;
   pid_out_type            pid_res;

   logic                   load_a, advance;
   logic                   a_valid_ff, a_valid_in;
   logic [SAMPLE_BITS-1:0] a_left_ff, a_middle_ff, a_right_ff;
   logic                   a_drive_ff;
   logic [SLOT_BITS-1:0]   slot_ff, slot_in;
   logic [MASK_BITS-1:0]   detect;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [MASK_BITS-1:0]   rsp_mask_ff;
   pid_out_type            rsp_res_ff;
   logic                   rsp_drive_ff;

   // configuration registers
   lfps_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .thr_cfg     (thr_cfg),
      .pid_cfg     (pid_cfg)
   );

   // pipeline handshake
   assign advance    = a_valid_ff & (~rsp_valid_ff | rsp_ready);
   assign req_ready  = ~a_valid_ff | advance;
   assign load_a     = req_valid & req_ready;
   assign a_valid_in = load_a | (a_valid_ff & ~advance);
   assign rsp_valid_in = advance | (rsp_valid_ff & ~rsp_ready);

   // history slot wraps after the last entry
   assign slot_in = (slot_ff == SLOT_BITS'(AVG_DEPTH - 1)) ? '0 : slot_ff + 1'b1;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_a) begin
         a_left_ff   <= req_left_sample;
         a_middle_ff <= req_middle_sample;
         a_right_ff  <= req_right_sample;
         a_drive_ff  <= req_drive_request;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
      end else if (advance) begin
         slot_ff <= slot_in;
      end
   end

   // sensor channels
   lfps_chan #(.SAMPLE_BITS(SAMPLE_BITS)) u_chan_left (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (advance),
      .slot      (slot_ff),
      .sample    (a_left_ff),
      .threshold (thr_cfg.left),
      .detect    (detect[0])
   );

   lfps_chan #(.SAMPLE_BITS(SAMPLE_BITS)) u_chan_middle (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (advance),
      .slot      (slot_ff),
      .sample    (a_middle_ff),
      .threshold (thr_cfg.middle),
      .detect    (detect[1])
   );

   lfps_chan #(.SAMPLE_BITS(SAMPLE_BITS)) u_chan_right (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (advance),
      .slot      (slot_ff),
      .sample    (a_right_ff),
      .threshold (thr_cfg.right),
      .detect    (detect[2])
   );

   // steering error and PID
   lfps_pid u_pid (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .detect (detect),
      .cfg    (pid_cfg),
      .result (pid_res)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_mask_ff  <= detect;
         rsp_res_ff   <= pid_res;
         rsp_drive_ff <= a_drive_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_detect_mask = rsp_mask_ff;
   assign rsp_line_error  = rsp_res_ff.line_error;
   assign rsp_correction  = rsp_res_ff.correction;
   assign rsp_left_drive  = rsp_res_ff.left_drive;
   assign rsp_right_drive = rsp_res_ff.right_drive;
   assign rsp_drive_valid = rsp_drive_ff;

endmodule

`default_nettype wire
